// ===== hdl/weighted_mean_window_filter_core_defines.svh =====
// Assertion helpers shared by the filter core
`ifndef WEIGHTED_MEAN_WINDOW_FILTER_CORE_DEFINES_SVH
`define WEIGHTED_MEAN_WINDOW_FILTER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define WMWF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define WMWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wmwf_pkg.sv =====
package wmwf_pkg;

  // Widths of fixed fields and internal arithmetic
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int OCOL_W  = 10;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 3;
  localparam int DIM_W   = 13;
  localparam int ACC_W   = 20;
  localparam int WSUM_W  = 12;
  localparam int STEP_W  = 3;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_WT_TOP = 3'd2,
    REG_WT_MID = 3'd3,
    REG_WT_BOT = 3'd4
  } cfg_idx_t;

  // 3x3 window, row-major, column 0 leftmost
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Sequencer of the core
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_CALC = 2'd2,
    S_EMIT = 2'd3
  } core_state_t;

  // Sequencer of the arithmetic unit
  typedef enum logic [1:0] {
    A_IDLE = 2'd0,
    A_MAC  = 2'd1,
    A_CHK  = 2'd2,
    A_DIV  = 2'd3
  } arith_state_t;

  // Result of one weighted mean
  typedef struct packed {
    logic             done;
    logic             err;
    logic [PIX_W-1:0] value;
  } arith_res_t;

endpackage

// ===== hdl/wmwf_line_mem.sv =====
module wmwf_line_mem import wmwf_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [2*PIX_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [2*PIX_W-1:0] wr_data
);

  // Older row in the high byte, newer row in the low byte
  logic [2*PIX_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/wmwf_arith.sv =====
module wmwf_arith import wmwf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CFG_W-1:0] wt_top,
  input  logic [CFG_W-1:0] wt_mid,
  input  logic [CFG_W-1:0] wt_bot,
  input  win_t             win,
  output arith_res_t       res
);

  arith_state_t      state_r, state_nxt;
  logic [1:0]        ri_r, cj_r;
  logic [ACC_W-1:0]  acc_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [STEP_W-1:0] k_r;
  logic [PIX_W-1:0]  q_r;
  logic              done_r, err_r;
  logic [CFG_W-1:0]  wrow;
  logic [PIX_W-1:0]  w_tap, p_tap;
  logic [3:0]        tap_idx;
  logic [2*PIX_W-1:0] prod;
  logic [ACC_W-1:0]  trial;
  logic              last_tap;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE: if (start) state_nxt = A_MAC;
      A_MAC:  if (last_tap) state_nxt = A_CHK;
      A_CHK:  state_nxt = (wsum_r == '0) ? A_IDLE : A_DIV;
      A_DIV:  if (k_r == '0) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  // Tap selection; weights apply mirrored across the row
  always_comb begin
    case (ri_r)
      2'd0:    wrow = wt_top;
      2'd1:    wrow = wt_mid;
      default: wrow = wt_bot;
    endcase
    case (cj_r)
      2'd0:    w_tap = wrow[23:16];
      2'd1:    w_tap = wrow[15:8];
      default: w_tap = wrow[7:0];
    endcase
    tap_idx  = 4'(ri_r) * 4'd3 + 4'(cj_r);
    p_tap    = win[tap_idx];
    prod     = w_tap * p_tap;
    last_tap = (ri_r == 2'd2) && (cj_r == 2'd2);
    trial    = ACC_W'(wsum_r) << k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == A_CHK) && (wsum_r == '0)) ||
                 ((state_r == A_DIV) && (k_r == '0));
    end
  end

  // Multiply-accumulate over the nine taps, then restoring division
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        ri_r   <= '0;
        cj_r   <= '0;
        acc_r  <= '0;
        wsum_r <= '0;
        k_r    <= STEP_W'(PIX_W - 1);
        q_r    <= '0;
      end
      A_MAC: begin
        acc_r  <= acc_r + ACC_W'(prod);
        wsum_r <= wsum_r + WSUM_W'(w_tap);
        if (cj_r == 2'd2) begin
          cj_r <= '0;
          ri_r <= ri_r + 2'd1;
        end else begin
          cj_r <= cj_r + 2'd1;
        end
      end
      A_CHK: begin
        err_r <= (wsum_r == '0);
      end
      A_DIV: begin
        if (acc_r >= trial) begin
          acc_r    <= acc_r - trial;
          q_r[k_r] <= 1'b1;
        end
        k_r <= k_r - STEP_W'(1);
      end
      default: ;
    endcase
  end

  assign res.done  = done_r;
  assign res.err   = err_r;
  assign res.value = err_r ? '0 : q_r;

endmodule

// ===== hdl/weighted_mean_window_filter_core.sv =====
// 3x3 weighted mean filter over a raster stream of 8-bit gray pixels. Each
// pixel transaction gives zero to three results tagged with row and column;
// tlast marks the final result of a pixel. Border rows and columns pass
// through, interior pixels are the truncated weighted mean with the kernel
// mirrored horizontally; a zero weight sum gives 0 with the error flag in
// tuser. When an interior value is due, the nine-tap multiply-accumulate,
// the zero check and the eight-step divider run one after the other, the
// divider being skipped when the weight sum is zero. Results then leave
// one at a time, and back-pressure on out_tready holds them back. The next
// pixel is taken only once all results have been loaded into the output
// register. The two previous rows sit in one line memory read and written
// once per pixel.
// Writing width or height restarts the frame at row 0, column 0.
`include "weighted_mean_window_filter_core_defines.svh"

module weighted_mean_window_filter_core import wmwf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] pixel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [7:0] out_value, [19:8] out_row, [29:20] out_col
  output logic              out_tuser,  // [0] zero_weight_error
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  core_state_t        state_r, state_nxt;
  logic [10:0]        width_r;
  logic [ROW_W-1:0]   height_r;
  logic [CFG_W-1:0]   wt_top_r, wt_mid_r, wt_bot_r;
  logic [ROW_W-1:0]   row_r, cur_row_r;
  logic [CW-1:0]      col_r, cur_col_r;
  logic [PIX_W-1:0]   pix_r, a_val_r, b_val_r;
  logic               a_err_r, start_r;
  logic [2:0]         pend_r;
  win_t               win_r;
  logic               out_tvalid_r, out_tlast_r, out_err_r;
  logic [PIX_W-1:0]   out_val_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [OCOL_W-1:0]  out_col_r;

  logic [DIM_W-1:0]   eff_w;
  logic [ROW_W-1:0]   eff_h;
  logic [ROW_W-1:0]   r0;
  logic [CW-1:0]      c0;
  logic               in_acc, out_free, emit_go;
  logic               mem_we;
  logic [2*PIX_W-1:0] mem_rd;
  logic               fl_a, fl_filt, fl_b, fl_c;
  logic               col_wrap;
  arith_res_t         ar;

  // Effective frame size
  always_comb begin
    if (width_r < 11'd3) eff_w = DIM_W'(3);
    else if (DIM_W'(width_r) > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    else eff_w = DIM_W'(width_r);
    eff_h = (height_r < 12'd3) ? 12'd3 : height_r;
  end

  // Position of the arriving pixel, restarting when out of frame
  always_comb begin
    if (row_r >= eff_h || DIM_W'(col_r) >= eff_w) begin
      r0 = '0;
      c0 = '0;
    end else begin
      r0 = row_r;
      c0 = col_r;
    end
  end

  // Results due for the current pixel
  always_comb begin
    fl_a     = (cur_row_r >= 12'd2) && (cur_col_r != '0);
    fl_filt  = fl_a && (cur_col_r != CW'(1));
    fl_b     = fl_a && (DIM_W'(cur_col_r) == eff_w - DIM_W'(1));
    fl_c     = (cur_row_r == '0) || (cur_row_r == eff_h - 12'd1);
    col_wrap = (DIM_W'(cur_col_r) + DIM_W'(1)) >= eff_w;
  end

  assign out_free = !out_tvalid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_READ;
      S_READ: begin
        if (fl_filt) state_nxt = S_CALC;
        else if (fl_a || fl_b || fl_c) state_nxt = S_EMIT;
        else state_nxt = S_IDLE;
      end
      S_CALC: if (ar.done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free && (pend_r == 3'b001 || pend_r == 3'b010 || pend_r == 3'b100))
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    mem_we    = (state_r == S_READ);
    emit_go   = (state_r == S_EMIT) && out_free;
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 12'd480;
      wt_top_r <= 24'h010101;
      wt_mid_r <= 24'h010101;
      wt_bot_r <= 24'h010101;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      if (state_r == S_READ) begin
        if (col_wrap) begin
          col_r <= '0;
          row_r <= (cur_row_r + 12'd1 >= eff_h) ? '0 : cur_row_r + 12'd1;
        end else begin
          col_r <= cur_col_r + CW'(1);
          row_r <= cur_row_r;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_WIDTH: begin
            width_r <= cfg_wdata[10:0];
            row_r   <= '0;
            col_r   <= '0;
          end
          REG_HEIGHT: begin
            height_r <= cfg_wdata[11:0];
            row_r    <= '0;
            col_r    <= '0;
          end
          REG_WT_TOP: wt_top_r <= cfg_wdata;
          REG_WT_MID: wt_mid_r <= cfg_wdata;
          REG_WT_BOT: wt_bot_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Line memory: read on accept, write back the shifted column
  wmwf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c0),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (cur_col_r),
    .wr_data ({mem_rd[PIX_W-1:0], pix_r})
  );

  // Capture the pixel and its position
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r     <= in_tdata;
      cur_row_r <= r0;
      cur_col_r <= c0;
    end
  end

  // Shift the window and load the new column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (state_r == S_READ) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= mem_rd[2*PIX_W-1:PIX_W];
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mem_rd[PIX_W-1:0];
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix_r;
    end
  end

  // Pending results and the values they carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= (state_r == S_READ) && fl_filt;
      if (state_r == S_READ) begin
        pend_r <= {fl_c, fl_b, fl_a};
      end else if (emit_go) begin
        if (pend_r[0]) pend_r[0] <= 1'b0;
        else if (pend_r[1]) pend_r[1] <= 1'b0;
        else pend_r[2] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      a_val_r <= win_r[5];
      a_err_r <= 1'b0;
      b_val_r <= mem_rd[PIX_W-1:0];
    end else if (state_r == S_CALC && ar.done) begin
      a_val_r <= ar.value;
      a_err_r <= ar.err;
    end
  end

  wmwf_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .wt_top (wt_top_r),
    .wt_mid (wt_mid_r),
    .wt_bot (wt_bot_r),
    .win    (win_r),
    .res    (ar)
  );

  // Output register: load the earliest pending result when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (pend_r[0]) begin
        out_val_r   <= a_val_r;
        out_row_r   <= cur_row_r - 12'd1;
        out_col_r   <= OCOL_W'(cur_col_r - CW'(1));
        out_err_r   <= a_err_r;
        out_tlast_r <= !(pend_r[1] || pend_r[2]);
      end else if (pend_r[1]) begin
        out_val_r   <= b_val_r;
        out_row_r   <= cur_row_r - 12'd1;
        out_col_r   <= OCOL_W'(cur_col_r);
        out_err_r   <= 1'b0;
        out_tlast_r <= !pend_r[2];
      end else begin
        out_val_r   <= pix_r;
        out_row_r   <= cur_row_r;
        out_col_r   <= OCOL_W'(cur_col_r);
        out_err_r   <= 1'b0;
        out_tlast_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_val_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_tlast_r;

  `WMWF_ASSERT_NEXT(a_accept_read, in_tvalid && in_tready, state_r == S_READ, "accept did not start a read")
  `WMWF_ASSERT_SAME(a_done_in_calc, ar.done, state_r == S_CALC, "arithmetic result outside calculation")
  `WMWF_ASSERT_SAME(a_idle_no_pend, in_tready, pend_r == '0 && !start_r, "input taken with work pending")

endmodule
